// ===== rtl/cmcu_pkg.sv =====
// Package for the micro-state control unit: state encoding, control word type,
// bus, address, inc/dec and ALU codes. Depends on nothing.
`default_nettype none

package cmcu_pkg;

    typedef enum logic [6:0] {
        MS_FETCH  = 7'd0,
        MS_DECODE = 7'd1,
        MS_INTR   = 7'd9,
        MS_HALT   = 7'd10,
        MS_11 = 7'd11, MS_12 = 7'd12, MS_13 = 7'd13, MS_14 = 7'd14,
        MS_15 = 7'd15, MS_16 = 7'd16, MS_17 = 7'd17,
        MS_20 = 7'd20, MS_21 = 7'd21, MS_22 = 7'd22, MS_23 = 7'd23, MS_24 = 7'd24,
        MS_26 = 7'd26, MS_27 = 7'd27, MS_28 = 7'd28, MS_29 = 7'd29, MS_30 = 7'd30,
        MS_31 = 7'd31, MS_32 = 7'd32, MS_33 = 7'd33, MS_34 = 7'd34, MS_35 = 7'd35,
        MS_36 = 7'd36, MS_37 = 7'd37, MS_38 = 7'd38,
        MS_JUMP = 7'd40, MS_41 = 7'd41,
        MS_G4   = 7'd60,
        MS_61 = 7'd61, MS_62 = 7'd62, MS_63 = 7'd63, MS_64 = 7'd64,
        MS_65 = 7'd65, MS_66 = 7'd66, MS_67 = 7'd67, MS_68 = 7'd68,
        MS_G5   = 7'd80,
        MS_81 = 7'd81, MS_82 = 7'd82, MS_83 = 7'd83, MS_84 = 7'd84, MS_85 = 7'd85,
        MS_86 = 7'd86, MS_87 = 7'd87, MS_88 = 7'd88, MS_89 = 7'd89, MS_90 = 7'd90
    } ms_t;

    localparam logic [2:0] OPC_G0 = 3'd0;
    localparam logic [2:0] OPC_G1 = 3'd1;
    localparam logic [2:0] OPC_G2 = 3'd2;
    localparam logic [2:0] OPC_G4 = 3'd4;
    localparam logic [2:0] OPC_G5 = 3'd5;

    localparam logic [1:0] G0_NOP  = 2'd0;
    localparam logic [1:0] G0_HALT = 2'd1;
    localparam logic [1:0] G0_OP2  = 2'd2;

    localparam logic [1:0] JC_ALWAYS = 2'd0;
    localparam logic [1:0] JC_CARRY  = 2'd1;
    localparam logic [1:0] JC_ZERO   = 2'd2;
    localparam logic [1:0] JC_SIGN   = 2'd3;

    localparam logic [1:0] ASEL_0 = 2'd0;
    localparam logic [1:0] ASEL_1 = 2'd1;
    localparam logic [1:0] ASEL_2 = 2'd2;
    localparam logic [1:0] ASEL_3 = 2'd3;

    localparam logic [3:0] REG_0  = 4'd0;
    localparam logic [3:0] REG_1  = 4'd1;
    localparam logic [3:0] REG_10 = 4'b1010;
    localparam logic [3:0] REG_11 = 4'b1011;
    localparam logic [3:0] REG_14 = 4'b1110;
    localparam logic [3:0] REG_15 = 4'b1111;

    localparam logic [2:0] IDS_0 = 3'd0;
    localparam logic [2:0] IDS_1 = 3'd1;
    localparam logic [2:0] IDS_2 = 3'd2;
    localparam logic [2:0] IDS_3 = 3'd3;

    localparam logic [3:0] ALU_NONE = 4'd0;
    localparam logic [3:0] ALU_2    = 4'b0010;
    localparam logic [3:0] ALU_3    = 4'b0011;
    localparam logic [3:0] ALU_4    = 4'd4;
    localparam logic [3:0] ALU_5    = 4'b0101;
    localparam logic [3:0] ALU_6    = 4'b0110;
    localparam logic [3:0] ALU_8    = 4'd8;
    localparam logic [3:0] ALU_13   = 4'b1101;
    localparam logic [3:0] ALU_14   = 4'b1110;
    localparam logic [3:0] ALU_15   = 4'b1111;

    typedef struct packed {
        logic [1:0] addr_src_sel;
        logic [3:0] bus_b_src;
        logic [3:0] bus_a_src;
        logic [2:0] incdec_sel;
        logic [3:0] bus_c_dst;
        logic       mem_not_io;
        logic       load_mar;
        logic       load_mbr;
        logic       write_strobe;
        logic       read_strobe;
        logic [3:0] alu_func;
        logic       load_flags;
    } ctrl_t;

    localparam ctrl_t CW_IDLE = '{ASEL_0, REG_0, REG_0, IDS_0, REG_0,
                                  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_NONE, 1'b0};

endpackage

`default_nettype wire

// ===== rtl/cpu_microstate_control_unit.sv =====
// Micro-state control unit: one control word per clock tick when not stalled, next
// micro-state from opcode, sub-opcode and flags. Depends on cmcu_pkg.
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | in        | in_valid / in_stall  | instr, irq, carry_flag, zero_flag, sign_flag
// out     | out       | out_valid / out_stall| control word fields
//
// One request is taken per cycle; its control word appears in the output
// register on the following cycle. The micro-state register advances at the
// same edge. Reset returns to fetch and empties the output register. A stall
// on the output holds the result and stalls the input while the register is full.
module cpu_microstate_control_unit
    import cmcu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] instr,
    input  wire logic        irq,
    input  wire logic        carry_flag,
    input  wire logic        zero_flag,
    input  wire logic        sign_flag,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       addr_src_sel,
    output logic [3:0]       bus_b_src,
    output logic [3:0]       bus_a_src,
    output logic [2:0]       incdec_sel,
    output logic [3:0]       bus_c_dst,
    output logic             mem_not_io,
    output logic             load_mar,
    output logic             load_mbr,
    output logic             write_strobe,
    output logic             read_strobe,
    output logic [3:0]       alu_func,
    output logic             load_flags
);

    ms_t        state_reg;
    ms_t        state_next;
    ctrl_t      cw_reg;
    ctrl_t      cw_next;
    logic       valid_reg;
    logic       accept;
    logic [3:0] r;
    logic [4:0] sub1;
    logic [3:0] sub5;
    ms_t        ends;
    logic       jump_taken;

    assign in_stall = valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign r        = instr[3:0];
    assign sub1     = instr[12:8];
    assign sub5     = instr[12:9];
    assign ends     = irq ? MS_INTR : MS_FETCH;

    always_comb
    begin
        case (instr[12:11])
            JC_ALWAYS: jump_taken = 1'b1;
            JC_CARRY:  jump_taken = carry_flag;
            JC_ZERO:   jump_taken = zero_flag;
            JC_SIGN:   jump_taken = sign_flag;
            default:   jump_taken = 1'b0;
        endcase
    end

    // next micro-state
    always_comb
    begin
        state_next = MS_FETCH;
        unique case (state_reg) inside
            MS_FETCH:  state_next = MS_DECODE;
            MS_DECODE:
            begin
                case (instr[15:13])
                    OPC_G0:
                    begin
                        case (instr[12:11])
                            G0_NOP:  state_next = ends;
                            G0_HALT: state_next = MS_HALT;
                            G0_OP2:  state_next = MS_11;
                            default: state_next = MS_15;
                        endcase
                    end
                    OPC_G1:
                    begin
                        if (sub1 == 5'd0)
                            state_next = MS_20;
                        else if (sub1 == 5'd1)
                            state_next = MS_21;
                        else if (sub1 <= 5'd3 || (sub1 >= 5'd5 && sub1 <= 5'd17))
                            state_next = ms_t'(7'(sub1) + 7'd21);
                        else
                            state_next = MS_FETCH;
                    end
                    OPC_G2:  state_next = MS_JUMP;
                    OPC_G4:  state_next = MS_G4;
                    OPC_G5:  state_next = MS_G5;
                    default: state_next = MS_FETCH;
                endcase
            end
            MS_INTR:   state_next = MS_INTR;
            MS_HALT:   state_next = irq ? MS_INTR : MS_HALT;
            MS_11:     state_next = MS_12;
            MS_12:     state_next = MS_13;
            MS_13:     state_next = MS_14;
            MS_15:     state_next = MS_16;
            MS_16:     state_next = MS_17;
            MS_21:     state_next = MS_22;
            MS_JUMP:   state_next = jump_taken ? MS_41 : ends;
            MS_G4:     state_next = ms_t'(7'(MS_61) + {4'b0, instr[12:10]});
            MS_G5:     state_next = (sub5 <= 4'd9) ? ms_t'(7'(MS_81) + {3'b0, sub5})
                                                   : MS_INTR;
            MS_14, MS_17, MS_20, MS_22, MS_23, MS_24, MS_41,
            [MS_26:MS_38], [MS_61:MS_68], [MS_81:MS_90]:
                       state_next = ends;
            default:   state_next = MS_FETCH;
        endcase
    end

    // control word of the current micro-state
    always_comb
    begin
        cw_next = CW_IDLE;
        unique case (state_reg) inside
            MS_FETCH, MS_INTR:
                cw_next = '{ASEL_1, REG_0, REG_0, IDS_1, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_11:
                cw_next = '{ASEL_2, REG_10, REG_0, IDS_3, REG_0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ALU_NONE, 1'b0};
            MS_12:
                cw_next = '{ASEL_2, REG_10, REG_1, IDS_3, REG_0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ALU_NONE, 1'b0};
            MS_13:
                cw_next = '{ASEL_0, REG_14, REG_11, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_NONE, 1'b0};
            MS_14:
                cw_next = '{ASEL_0, REG_15, REG_10, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_NONE, 1'b0};
            MS_15, MS_21:
                cw_next = '{ASEL_0, REG_0, REG_1, IDS_2, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_NONE, 1'b0};
            MS_16:
                cw_next = '{ASEL_2, REG_0, REG_10, IDS_2, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_17:
                cw_next = '{ASEL_2, REG_0, REG_11, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_20:
                cw_next = '{ASEL_2, r, REG_1, IDS_3, REG_0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ALU_NONE, 1'b0};
            MS_22:
                cw_next = '{ASEL_2, REG_0, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_23:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_5, 1'b0};
            MS_24:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_13, 1'b1};
            MS_26:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_8, 1'b0};
            MS_27:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_15, 1'b0};
            MS_28:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_14, 1'b0};
            MS_29:
                cw_next = '{ASEL_0, REG_0, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_30:
                cw_next = '{ASEL_0, r, REG_1, IDS_0, REG_0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ALU_NONE, 1'b0};
            MS_31:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_2, 1'b1};
            MS_32:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_3, 1'b1};
            MS_33:
                cw_next = '{ASEL_0, r, REG_1, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_3, 1'b1};
            MS_34:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_5, 1'b1};
            MS_35:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_4, 1'b1};
            MS_36:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_6, 1'b1};
            MS_37:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_38:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, ALU_NONE, 1'b0};
            MS_JUMP:
                cw_next = '{ASEL_1, REG_0, REG_1, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_41:
                cw_next = '{ASEL_0, REG_11, REG_11, IDS_0, REG_1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_2, 1'b1};
            MS_G4:
                cw_next = '{ASEL_1, REG_0, REG_1, IDS_1, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_61:
                cw_next = '{ASEL_0, REG_1, r, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_NONE, 1'b0};
            MS_62:
                cw_next = '{ASEL_0, REG_15, r, IDS_0, REG_0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_NONE, 1'b0};
            MS_63:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_2, 1'b1};
            MS_64:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_3, 1'b1};
            MS_65:
                cw_next = '{ASEL_0, r, REG_1, IDS_0, REG_1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_3, 1'b1};
            MS_66:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_5, 1'b0};
            MS_67:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_4, 1'b0};
            MS_68:
                cw_next = '{ASEL_0, r, r, IDS_0, REG_1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ALU_6, 1'b1};
            MS_82:
                cw_next = '{ASEL_3, REG_0, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_NONE, 1'b0};
            MS_83:
                cw_next = '{ASEL_3, r, REG_1, IDS_0, REG_0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ALU_NONE, 1'b0};
            MS_84:
                cw_next = '{ASEL_3, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_2, 1'b1};
            MS_85:
                cw_next = '{ASEL_3, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_3, 1'b1};
            MS_86:
                cw_next = '{ASEL_3, r, REG_1, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_3, 1'b1};
            MS_87:
                cw_next = '{ASEL_3, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_5, 1'b0};
            MS_88:
                cw_next = '{ASEL_3, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_4, 1'b0};
            MS_89:
                cw_next = '{ASEL_3, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, ALU_6, 1'b1};
            MS_90:
                cw_next = '{ASEL_3, r, r, IDS_0, REG_0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ALU_6, 1'b1};
            default:
                cw_next = CW_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_FETCH;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    // hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
            cw_reg <= cw_next;
    end

    assign out_valid    = valid_reg;
    assign addr_src_sel = cw_reg.addr_src_sel;
    assign bus_b_src    = cw_reg.bus_b_src;
    assign bus_a_src    = cw_reg.bus_a_src;
    assign incdec_sel   = cw_reg.incdec_sel;
    assign bus_c_dst    = cw_reg.bus_c_dst;
    assign mem_not_io   = cw_reg.mem_not_io;
    assign load_mar     = cw_reg.load_mar;
    assign load_mbr     = cw_reg.load_mbr;
    assign write_strobe = cw_reg.write_strobe;
    assign read_strobe  = cw_reg.read_strobe;
    assign alu_func     = cw_reg.alu_func;
    assign load_flags   = cw_reg.load_flags;

endmodule

`default_nettype wire
